>>> rtl/core/jeoif_pkg.sv
package jeoif_pkg;

  // default width of the offset space that the reported end saturates to
  localparam int unsigned OFFSET_BITS_DEF = 32;

  // marker codes
  localparam logic [7:0] BYTE_FILL = 8'hFF;
  localparam logic [7:0] MRK_SOI   = 8'hD8;
  localparam logic [7:0] MRK_EOI   = 8'hD9;
  localparam logic [7:0] MRK_SOS   = 8'hDA;
  localparam logic [7:0] MRK_RST0  = 8'hD0;
  localparam logic [7:0] MRK_RST7  = 8'hD7;
  localparam logic [7:0] MRK_TEM   = 8'h01;
  localparam logic [7:0] BYTE_STUF = 8'h00;

  // result status codes
  typedef enum logic [1:0] {
    ST_END     = 2'd0,
    ST_NO_SOI  = 2'd1,
    ST_BAD_LEN = 2'd2,
    ST_NO_DATA = 2'd3
  } status_t;

  // parser modes
  typedef enum logic [3:0] {
    MODE_IDLE    = 4'd0,
    MODE_SOI2    = 4'd1,
    MODE_SEEK    = 4'd2,
    MODE_FILL    = 4'd3,
    MODE_LEN_HI  = 4'd4,
    MODE_LEN_LO  = 4'd5,
    MODE_SKIP    = 4'd6,
    MODE_SCAN    = 4'd7,
    MODE_SCAN_FF = 4'd8
  } mode_t;

endpackage

>>> rtl/core/jpeg_end_of_image_finder_top.sv
// channel  | direction | tdata                  | tuser               | tlast
// in_      | slave     | [7:0] byte_value       | [0] start_of_image  | end_of_buffer
// out_     | master    | [31:0] end_offset      | [1:0] status        | -
// cfg_     | write     | [31:0] base_offset     | -                   | -
//
// one byte is taken every cycle while in_tready is high; the parser state and the running end offset
// are updated in the cycle the byte is accepted; the result is registered in the output register or skid entry
// a two-entry output buffer (output register plus skid) parts the two sides;
// in_tready drops only while both entries hold a result
// rst_n is synchronous, active low, and returns the parser to idle with no result
// base_offset must be written only while the parser is idle; the block does not enforce this
module jpeg_end_of_image_finder_top
  import jeoif_pkg::*;
#(
  parameter int unsigned OFFSET_BITS = OFFSET_BITS_DEF
) (
  input  logic        clk,
  input  logic        rst_n,
  // configuration
  input  logic        cfg_wr_en,
  input  logic [31:0] cfg_wr_data,   // base_offset
  // byte stream
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [7:0]  in_tdata,      // [7:0] byte_value
  input  logic        in_tuser,      // [0] start_of_image
  input  logic        in_tlast,      // end_of_buffer
  // results
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [31:0] out_tdata,     // [31:0] end_offset
  output logic [1:0]  out_tuser      // [1:0] status
);

  // largest end offset that can be reported
  localparam logic [63:0] OFFSET_MASK = (64'd1 << (OFFSET_BITS % 64)) - 64'd1;
  localparam logic [31:0] OFFSET_MAX  = (OFFSET_BITS >= 32) ? 32'hFFFF_FFFF
                                                            : OFFSET_MASK[31:0];

  logic [31:0] base_r;
  mode_t       mode_r, mode_nxt;
  logic [31:0] end_r, end_nxt;        // saturated base plus byte count
  logic [15:0] skip_r, skip_nxt;
  logic [7:0]  len_hi_r, len_hi_nxt;
  logic        after_sos_r, after_sos_nxt;

  logic        out_valid_r;
  status_t     out_status_r;
  logic [31:0] out_offset_r;
  logic        skid_valid_r;
  status_t     skid_status_r;
  logic [31:0] skid_offset_r;

  logic        in_fire;
  logic        emit;
  status_t     res_status;
  logic [31:0] res_offset;

  logic [7:0]  b;
  logic        is_rst;
  logic        is_eoi;
  logic        is_standalone;
  logic [15:0] seg_len;
  logic [15:0] skip_dec;
  logic [32:0] first_sum;
  logic [31:0] end_inc;

  assign in_tready = !skid_valid_r;
  assign in_fire   = in_tvalid && in_tready;
  assign b         = in_tdata;

  // marker decode
  assign is_rst        = (b >= MRK_RST0) && (b <= MRK_RST7);
  assign is_eoi        = (b == MRK_EOI);
  assign is_standalone = (b == MRK_TEM) || is_rst;
  assign seg_len       = {len_hi_r, b};
  assign skip_dec      = (skip_r != 16'd0) ? (skip_r - 16'd1) : skip_r;

  // running end offset
  assign first_sum = {1'b0, base_r} + 33'd1;
  assign end_inc   = (end_r == OFFSET_MAX) ? end_r : (end_r + 32'd1);

  // parser next state and result
  always_comb begin
    mode_nxt      = mode_r;
    end_nxt       = end_r;
    skip_nxt      = skip_r;
    len_hi_nxt    = len_hi_r;
    after_sos_nxt = after_sos_r;
    emit          = 1'b0;
    res_status    = ST_END;

    if (in_tuser) begin
      end_nxt       = (first_sum > {1'b0, OFFSET_MAX}) ? OFFSET_MAX : first_sum[31:0];
      skip_nxt      = 16'd0;
      len_hi_nxt    = 8'd0;
      after_sos_nxt = 1'b0;
      if (b != BYTE_FILL || in_tlast) begin
        emit       = 1'b1;
        res_status = ST_NO_SOI;
      end else begin
        mode_nxt = MODE_SOI2;
      end
    end else if (mode_r != MODE_IDLE) begin
      end_nxt = end_inc;
      case (mode_r)
        MODE_SOI2: begin
          if (b != MRK_SOI) begin
            emit       = 1'b1;
            res_status = ST_NO_SOI;
          end else begin
            mode_nxt = MODE_SEEK;
          end
        end
        MODE_SEEK: begin
          if (b == BYTE_FILL) mode_nxt = MODE_FILL;
        end
        MODE_FILL, MODE_SCAN_FF: begin
          if (mode_r == MODE_SCAN_FF && (b == BYTE_STUF || is_rst)) begin
            mode_nxt = MODE_SCAN;
          end else if (b != BYTE_FILL) begin
            if (is_eoi) begin
              emit       = 1'b1;
              res_status = ST_END;
            end else if (is_standalone) begin
              mode_nxt = MODE_SEEK;
            end else begin
              after_sos_nxt = (b == MRK_SOS);
              mode_nxt      = MODE_LEN_HI;
            end
          end
        end
        MODE_LEN_HI: begin
          len_hi_nxt = b;
          mode_nxt   = MODE_LEN_LO;
        end
        MODE_LEN_LO: begin
          if (seg_len < 16'd2) begin
            emit       = 1'b1;
            res_status = ST_BAD_LEN;
          end else begin
            skip_nxt = seg_len - 16'd2;
            if (seg_len != 16'd2) mode_nxt = MODE_SKIP;
            else mode_nxt = after_sos_r ? MODE_SCAN : MODE_SEEK;
          end
        end
        MODE_SKIP: begin
          skip_nxt = skip_dec;
          if (skip_dec == 16'd0) mode_nxt = after_sos_r ? MODE_SCAN : MODE_SEEK;
        end
        MODE_SCAN: begin
          if (b == BYTE_FILL) mode_nxt = MODE_SCAN_FF;
        end
        default: begin
          mode_nxt = MODE_IDLE;
        end
      endcase
      // buffer ran out without an end marker
      if (!emit && in_tlast && mode_r inside {MODE_SOI2, MODE_SEEK, MODE_FILL,
          MODE_LEN_HI, MODE_LEN_LO, MODE_SKIP, MODE_SCAN, MODE_SCAN_FF}) begin
        emit       = 1'b1;
        res_status = ST_NO_DATA;
      end
    end

    if (emit) mode_nxt = MODE_IDLE;
    res_offset = (emit && res_status == ST_END) ? end_nxt : 32'd0;
  end

  // configuration register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      base_r <= 32'd0;
    end else if (cfg_wr_en) begin
      base_r <= cfg_wr_data;
    end
  end

  // parser state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mode_r      <= MODE_IDLE;
      end_r       <= 32'd0;
      skip_r      <= 16'd0;
      len_hi_r    <= 8'd0;
      after_sos_r <= 1'b0;
    end else if (in_fire) begin
      mode_r      <= mode_nxt;
      end_r       <= end_nxt;
      skip_r      <= skip_nxt;
      len_hi_r    <= len_hi_nxt;
      after_sos_r <= after_sos_nxt;
    end
  end

  // output register and skid entry
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r  <= 1'b0;
      skid_valid_r <= 1'b0;
    end else if (!out_valid_r || out_tready) begin
      if (skid_valid_r) begin
        out_valid_r  <= 1'b1;
        skid_valid_r <= 1'b0;
      end else begin
        out_valid_r <= in_fire && emit;
      end
    end else if (in_fire && emit) begin
      skid_valid_r <= 1'b1;
    end
  end

  // result payload
  always_ff @(posedge clk) begin
    if (!out_valid_r || out_tready) begin
      if (skid_valid_r) begin
        out_status_r <= skid_status_r;
        out_offset_r <= skid_offset_r;
      end else begin
        out_status_r <= res_status;
        out_offset_r <= res_offset;
      end
    end else if (in_fire && emit) begin
      skid_status_r <= res_status;
      skid_offset_r <= res_offset;
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_offset_r;
  assign out_tuser  = out_status_r;

endmodule

>>> rtl/core/jeoif_checker.sv
module jeoif_checker
  import jeoif_pkg::*;
(
  input logic        clk,
  input logic        rst_n,
  input logic        in_tvalid,
  input logic        in_tready,
  input logic [7:0]  in_tdata,
  input logic        in_tuser,
  input logic        in_tlast,
  input logic        out_tvalid,
  input logic        out_tready,
  input logic [31:0] out_tdata,
  input logic [1:0]  out_tuser
);

  // input stalls only when a result is already waiting at the output
  a_stall_needs_result: assert property (@(posedge clk) disable iff (!rst_n)
    !in_tready |-> out_tvalid)
    else $error("input stalled with no result pending");

  // offset is zero for every error status
  a_err_offset_zero: assert property (@(posedge clk) disable iff (!rst_n)
    (out_tvalid && out_tuser != ST_END) |-> (out_tdata == 32'd0))
    else $error("error result carries a nonzero offset");

  // a start byte that is not a fill byte, or also ends the buffer, yields a result
  a_bad_start_result: assert property (@(posedge clk) disable iff (!rst_n)
    (in_tvalid && in_tready && in_tuser && (in_tdata != BYTE_FILL || in_tlast))
      |=> out_tvalid)
    else $error("bad start item gave no result");

  // a stalled result holds
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    (out_tvalid && !out_tready) |=>
      (out_tvalid && $stable(out_tdata) && $stable(out_tuser)))
    else $error("stalled result changed");

  // reset leaves no result behind
  a_reset_clear: assert property (@(posedge clk)
    !rst_n |=> !out_tvalid)
    else $error("result valid after reset");

endmodule

bind jpeg_end_of_image_finder_top jeoif_checker u_jeoif_checker (.*);
